// ===== src/adsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg: shared constants and helpers
// Field widths, register indexes and the Q1.16 unity constant of the envelope.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int unsigned FracW   = 17;
  localparam int unsigned PerW    = 16;
  localparam int unsigned StepsW  = 5;
  localparam int unsigned PosW    = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned DefMaxNoteSteps = 16;

  localparam logic [FracW-1:0] OneQ16 = 17'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_SUSTAIN = 3'd2,
    CFG_RELEASE = 3'd3,
    CFG_STEP    = 3'd4
  } cfg_idx_e;

  function automatic logic [FracW-1:0] sat_one(input logic [FracW-1:0] v);
    sat_one = (v > OneQ16) ? OneQ16 : v;
  endfunction

endpackage

// ===== src/adsr_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_div_cell: one quotient bit of a pipelined restoring divider
// Compares the partial remainder against the shifted divisor, subtracts on a
// hit and sets quotient bit BIT, then hands everything to the next cell.
// ----------------------------------------------------------------------------
module adsr_div_cell #(
  parameter int unsigned DW  = 17,
  parameter int unsigned QW  = 17,
  parameter int unsigned SW  = 1,
  parameter int unsigned BIT = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DW+QW-1:0] rem_i,
  input  logic [DW-1:0]    den_i,
  input  logic [QW-1:0]    quo_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [DW+QW-1:0] rem_o,
  output logic [DW-1:0]    den_o,
  output logic [QW-1:0]    quo_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned RW = DW + QW;

  logic [RW-1:0] shifted;
  logic          hit;
  logic [RW-1:0] rem_d;
  logic [QW-1:0] quo_d;

  assign shifted = RW'(den_i) << BIT;
  assign hit     = (rem_i >= shifted);
  assign rem_d   = hit ? (rem_i - shifted) : rem_i;
  assign quo_d   = quo_i | (QW'(hit) << BIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      den_o  <= den_i;
      quo_o  <= quo_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== src/adsr_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_div_chain: row of divider cells
// QW cells, most significant quotient bit first, one word in flight per cell.
// ----------------------------------------------------------------------------
module adsr_div_chain #(
  parameter int unsigned DW = 17,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quo_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned RW = DW + QW;

  logic          vld_w  [QW+1];
  logic [RW-1:0] rem_w  [QW+1];
  logic [DW-1:0] den_w  [QW+1];
  logic [QW-1:0] quo_w  [QW+1];
  logic [SW-1:0] side_w [QW+1];

  assign vld_w[0]  = valid_i;
  assign rem_w[0]  = num_i;
  assign den_w[0]  = den_i;
  assign quo_w[0]  = '0;
  assign side_w[0] = side_i;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    adsr_div_cell #(
      .DW (DW),
      .QW (QW),
      .SW (SW),
      .BIT(QW - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(vld_w[i]),
      .rem_i  (rem_w[i]),
      .den_i  (den_w[i]),
      .quo_i  (quo_w[i]),
      .side_i (side_w[i]),
      .valid_o(vld_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .den_o  (den_w[i+1]),
      .quo_o  (quo_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  assign valid_o = vld_w[QW];
  assign quo_o   = quo_w[QW];
  assign side_o  = side_w[QW];

endmodule

// ===== src/adsr_envelope_level.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_level: attack/decay/sustain/release gain at a sample position
// Accepts one word per cycle while in_stall_o is low and returns its gain via
// step clamping and note length in registers a and b, a 17-cell divider chain
// for the normalized time, a phase-selection register, one multiply, a second
// 17-cell divider chain and the output register; one quotient bit per cell.
// Configuration must be written while no word is in flight.
// ----------------------------------------------------------------------------
module adsr_envelope_level
  import adsr_pkg::*;
#(
  parameter int unsigned MAX_NOTE_STEPS = DefMaxNoteSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [StepsW-1:0]  note_steps_i,
  input  logic [PosW-1:0]    sample_pos_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FracW-1:0]   gain_o,
  output logic               pos_clamped_o
);

  localparam int unsigned NSW = $clog2(MAX_NOTE_STEPS + 1);
  localparam int unsigned LW  = NSW + PerW;
  localparam int unsigned CW  = (LW > PosW) ? LW : PosW;
  localparam int unsigned SCW = (NSW > StepsW) ? NSW : StepsW;
  localparam int unsigned QW  = FracW;
  localparam int unsigned PW  = 2 * FracW;

  logic [FracW-1:0] attack_q, decay_q, sustain_q, release_q;
  logic [PerW-1:0]  step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      decay_q   <= '0;
      sustain_q <= OneQ16;
      release_q <= '0;
      step_q    <= PerW'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATTACK:  attack_q  <= cfg_data_i;
        CFG_DECAY:   decay_q   <= cfg_data_i;
        CFG_SUSTAIN: sustain_q <= cfg_data_i;
        CFG_RELEASE: release_q <= cfg_data_i;
        CFG_STEP:    step_q    <= cfg_data_i[PerW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // clamp step count and step length
  logic [NSW-1:0]  steps_d;
  logic [PerW-1:0] per_d;

  always_comb begin
    if (note_steps_i == '0) begin
      steps_d = NSW'(1);
    end else if (SCW'(note_steps_i) > SCW'(MAX_NOTE_STEPS)) begin
      steps_d = NSW'(MAX_NOTE_STEPS);
    end else begin
      steps_d = NSW'(note_steps_i);
    end
    per_d = (step_q < PerW'(2)) ? PerW'(2) : step_q;
  end

  logic            a_vld_q;
  logic [NSW-1:0]  a_steps_q;
  logic [PerW-1:0] a_per_q;
  logic [PosW-1:0] a_pos_q;
  logic            b_vld_q;
  logic [LW-1:0]   b_last_q;
  logic [PosW-1:0] b_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_steps_q <= steps_d;
      a_per_q   <= per_d;
      a_pos_q   <= sample_pos_i;
      b_last_q  <= LW'(a_steps_q) * LW'(a_per_q) - LW'(1);
      b_pos_q   <= a_pos_q;
    end
  end

  // clamp position, then normalize
  logic          flag_b;
  logic [CW-1:0] pos_c;
  logic [LW+QW-1:0] num1;

  assign flag_b = CW'(b_pos_q) > CW'(b_last_q);
  assign pos_c  = flag_b ? CW'(b_last_q) : CW'(b_pos_q);
  assign num1   = (LW+QW)'({pos_c[LW-1:0], 16'd0});

  logic          c1_vld;
  logic [QW-1:0] t_c1;
  logic          flag_c1;

  adsr_div_chain #(
    .DW(LW),
    .QW(QW),
    .SW(1)
  ) u_time_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(b_vld_q),
    .num_i  (num1),
    .den_i  (b_last_q),
    .side_i (flag_b),
    .valid_o(c1_vld),
    .quo_o  (t_c1),
    .side_o (flag_c1)
  );

  // phase selection
  logic [FracW-1:0] sa, sd, ss, sr, rest;
  logic [FracW:0]   apd;
  logic [FracW-1:0] mula_d, mulb_d, den_d, base_d;
  logic             sub_d;

  always_comb begin
    sa     = sat_one(attack_q);
    sd     = sat_one(decay_q);
    ss     = sat_one(sustain_q);
    sr     = sat_one(release_q);
    apd    = {1'b0, sa} + {1'b0, sd};
    rest   = OneQ16 - t_c1;
    mula_d = '0;
    mulb_d = '0;
    den_d  = FracW'(1);
    base_d = ss;
    sub_d  = 1'b0;
    if (t_c1 < sa) begin
      mula_d = t_c1;
      mulb_d = OneQ16;
      den_d  = sa;
      base_d = '0;
    end else if ({1'b0, t_c1} < apd) begin
      mula_d = OneQ16 - ss;
      mulb_d = FracW'(apd - {1'b0, t_c1});
      den_d  = sd;
    end else if (rest > sr) begin
      base_d = ss;
    end else if (sr != '0) begin
      mula_d = ss;
      mulb_d = sr - rest;
      den_d  = sr;
      sub_d  = 1'b1;
    end
  end

  logic             d_vld_q, e_vld_q;
  logic [FracW-1:0] d_mula_q, d_mulb_q, d_den_q, d_base_q, e_den_q, e_base_q;
  logic             d_sub_q, d_flag_q, e_sub_q, e_flag_q;
  logic [PW-1:0]    e_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c1_vld;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_mula_q <= mula_d;
      d_mulb_q <= mulb_d;
      d_den_q  <= den_d;
      d_base_q <= base_d;
      d_sub_q  <= sub_d;
      d_flag_q <= flag_c1;
      e_prod_q <= PW'(d_mula_q) * PW'(d_mulb_q);
      e_den_q  <= d_den_q;
      e_base_q <= d_base_q;
      e_sub_q  <= d_sub_q;
      e_flag_q <= d_flag_q;
    end
  end

  logic             c2_vld;
  logic [QW-1:0]    q_c2;
  logic [FracW+1:0] side2_in, side2_out;

  assign side2_in = {e_base_q, e_sub_q, e_flag_q};

  adsr_div_chain #(
    .DW(FracW),
    .QW(QW),
    .SW(FracW + 2)
  ) u_gain_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(e_vld_q),
    .num_i  (e_prod_q),
    .den_i  (e_den_q),
    .side_i (side2_in),
    .valid_o(c2_vld),
    .quo_o  (q_c2),
    .side_o (side2_out)
  );

  logic [FracW-1:0] base_f;
  logic [FracW-1:0] gain_d;

  assign base_f = side2_out[FracW+1:2];
  assign gain_d = side2_out[1] ? (base_f - q_c2) : (base_f + q_c2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= c2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gain_o        <= gain_d;
      pos_clamped_o <= side2_out[0];
    end
  end

endmodule
